FILE: hdl/lbs_pkg.sv
package lbs_pkg;

  localparam int unsigned PaletteEntriesDefault = 64;
  localparam int unsigned MaxInfluencesDefault  = 4;
  localparam int unsigned ItemInfluences        = 4;
  localparam int unsigned MatrixWords           = 12;
  localparam int unsigned BoneIndexWidth        = 6;
  localparam logic [16:0] WeightOne             = 17'd65536;
  localparam logic [16:0] ThresholdReset        = 17'd655;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SKIN_P = 2'd1,
    OP_SKIN_N = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [23:0]        bone_indices;
    logic [16:0]        weight_first;
    logic [16:0]        weight_second;
    logic [16:0]        weight_third;
    logic [16:0]        weight_fourth;
    logic [5:0]         palette_entry;
    logic [3:0]         palette_word;
    logic signed [31:0] palette_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // Clamp a 17-bit weight to one.
  function automatic logic [16:0] sat_weight(input logic [16:0] w);
    sat_weight = (w > WeightOne) ? WeightOne : w;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      sat32 = -32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: hdl/lbs_ram.sv
module lbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/linear_blend_skinning.sv
// Vertex skinning engine with a bone palette of PaletteEntries 4x3 matrices in
// one single-port-read RAM. A load item writes one palette word.
// A skin item walks at most MaxInfluences of its four influences in order,
// stopping at the first weight below the threshold; each influence takes a
// check state, twelve palette reads whose products trail the registered read,
// and three weight products, since one shared 32x32 multiplier forms the nine
// matrix products and three weight products one at a time, fed by one palette read per cycle.
// No new item is taken until the result has left the output register.
// Reading a palette word that was never written gives an undefined result.
module linear_blend_skinning
  import lbs_pkg::*;
#(
  parameter int unsigned PaletteEntries = PaletteEntriesDefault,
  parameter int unsigned MaxInfluences  = MaxInfluencesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbs_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbs_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [16:0]         cfg_data_i
);

  localparam int unsigned Depth  = PaletteEntries * MatrixWords;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned Count  = (MaxInfluences < ItemInfluences) ? MaxInfluences
                                                                     : ItemInfluences;
  localparam int unsigned InflW  = $clog2(ItemInfluences + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_WEIGHT,
    ST_DONE
  } state_e;

  state_e             state_q;
  in_item_t           item_q;
  logic [16:0]        thresh_q;
  logic [InflW-1:0]   infl_q;
  logic [3:0]         step_q;      // 0..11 reads; the MAC trails the registered read
  logic               rd_vld_q;
  logic [3:0]         rd_step_q;
  logic               bone_ok_q;
  logic signed [49:0] term_q [3];
  logic signed [39:0] acc_q [3];
  logic [1:0]         wc_q;
  out_item_t          out_q;
  logic               out_vld_q;

  // Current influence's bone index and weight.
  logic [BoneIndexWidth-1:0] bone;
  logic [16:0]               wcur;
  always_comb begin
    bone = item_q.bone_indices[6*infl_q[1:0] +: BoneIndexWidth];
    case (infl_q[1:0])
      2'd0:    wcur = sat_weight(item_q.weight_first);
      2'd1:    wcur = sat_weight(item_q.weight_second);
      2'd2:    wcur = sat_weight(item_q.weight_third);
      default: wcur = sat_weight(item_q.weight_fourth);
    endcase
  end

  // Palette RAM; load writes, the sequencer reads.
  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic [31:0]          rdata;
  logic                 in_acc;
  logic [AddrW+3:0]     waddr_w, raddr_w;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign waddr_w = (AddrW+4)'(in_item_i.palette_entry) * (AddrW+4)'(MatrixWords)
                 + (AddrW+4)'(in_item_i.palette_word);
  assign we      = in_acc && (op_e'(in_item_i.operation) == OP_LOAD) &&
                   ((32)'(in_item_i.palette_entry) < PaletteEntries) &&
                   (in_item_i.palette_word < 4'(MatrixWords));
  assign waddr   = waddr_w[AddrW-1:0];
  assign raddr_w = (AddrW+4)'(bone) * (AddrW+4)'(MatrixWords) + (AddrW+4)'(step_q);
  assign raddr   = raddr_w[AddrW-1:0];

  lbs_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_item_i.palette_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Shared multiplier: matrix word times coordinate, or term times weight.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;
  logic [1:0]         mrow, mcol;
  always_comb begin
    // Row and column of the palette word that arrives this cycle.
    case (rd_step_q)
      4'd0, 4'd1, 4'd2: mrow = 2'd0;
      4'd3, 4'd4, 4'd5: mrow = 2'd1;
      4'd6, 4'd7, 4'd8: mrow = 2'd2;
      default:          mrow = 2'd3;
    endcase
    case (rd_step_q)
      4'd0, 4'd3, 4'd6, 4'd9:  mcol = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: mcol = 2'd1;
      default:                 mcol = 2'd2;
    endcase
    mul_a = bone_ok_q ? rdata : 32'sd0;
    case (mrow)
      2'd0:    mul_b = item_q.coord_x;
      2'd1:    mul_b = item_q.coord_y;
      default: mul_b = item_q.coord_z;
    endcase
    if (state_q == ST_WEIGHT) begin
      mul_a = sat32(64'(term_q[wc_q]));
      mul_b = {15'd0, wcur};
    end
    prod    = mul_a * mul_b;
    prod_sh = prod[63:16];
  end

  assign in_stall_o  = (state_q != ST_IDLE) || out_vld_q;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      thresh_q  <= ThresholdReset;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      infl_q    <= '0;
      step_q    <= '0;
      wc_q      <= '0;
    end else begin
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) thresh_q <= cfg_data_i;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (op_e'(in_item_i.operation) == OP_SKIN_P ||
                         op_e'(in_item_i.operation) == OP_SKIN_N)) begin
            item_q <= in_item_i;
            infl_q <= '0;
            for (int c = 0; c < 3; c++) acc_q[c] <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          for (int c = 0; c < 3; c++) term_q[c] <= '0;
          step_q   <= '0;
          rd_vld_q <= 1'b0;
          if ((32)'(infl_q) >= Count || wcur < sat_weight(thresh_q)) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          rd_vld_q  <= (step_q < 4'd12);
          rd_step_q <= step_q;
          bone_ok_q <= (32)'(bone) < PaletteEntries;
          if (step_q < 4'd12) step_q <= step_q + 4'd1;
          if (rd_vld_q) begin
            if (rd_step_q < 4'd9) begin
              term_q[mcol] <= term_q[mcol] + 50'(prod_sh);
            end else if (op_e'(item_q.operation) == OP_SKIN_P) begin
              term_q[mcol] <= term_q[mcol] + 50'(mul_a);
            end
          end
          if (rd_vld_q && rd_step_q == 4'd11) begin
            wc_q    <= '0;
            state_q <= ST_WEIGHT;
          end
        end
        ST_WEIGHT: begin
          acc_q[wc_q] <= acc_q[wc_q] + 40'(prod_sh);
          if (wc_q == 2'd2) begin
            infl_q  <= infl_q + InflW'(1);
            state_q <= ST_CHECK;
          end else begin
            wc_q <= wc_q + 2'd1;
          end
        end
        ST_DONE: begin
          if (!out_vld_q) begin
            out_q.out_x <= sat32(64'(acc_q[0]));
            out_q.out_y <= sat32(64'(acc_q[1]));
            out_q.out_z <= sat32(64'(acc_q[2]));
            out_vld_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The output register is only loaded when empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q)
    else $error("result dropped while stalled");
  // No item is taken while a skin item is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_acc)
    else $error("item accepted while busy");
  // The influence counter never passes the influence count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32)'(infl_q) <= Count)
    else $error("influence counter overflow");

endmodule
